/* hw/rtl/kked_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kked_pkg
// Types and constants shared by the keypad key event detector files.
// ----------------------------------------------------------------------------
package kked_pkg;

    localparam int ROWS     = 4;
    localparam int COLUMNS  = 4;
    localparam int NUM_KEYS = ROWS * COLUMNS;

    localparam int KEY_W   = 4;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CLICK_W = 3;
    localparam int CODE_W  = 3;
    localparam int CIDX_W  = 3;
    localparam int DEPTH   = 2 ** KEY_W;

    localparam logic [CFG_W-1:0]   DEBOUNCE_RST   = 16'd20;
    localparam logic [CFG_W-1:0]   CLICK_MIN_RST  = 16'd20;
    localparam logic [CFG_W-1:0]   CLICK_MAX_RST  = 16'd300;
    localparam logic [CFG_W-1:0]   GAP_RST        = 16'd400;
    localparam logic [CFG_W-1:0]   HOLD_RST       = 16'd1000;
    localparam logic [CLICK_W-1:0] MAX_CLICKS_RST = 3'd3;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE     = 3'd0,
        EV_PRESSED  = 3'd1,
        EV_RELEASED = 3'd2,
        EV_HOLD     = 3'd3,
        EV_CLICKED  = 3'd4
    } t_event;

    typedef enum logic [CIDX_W-1:0] {
        CFG_DEBOUNCE   = 3'd0,
        CFG_CLICK_MIN  = 3'd1,
        CFG_CLICK_MAX  = 3'd2,
        CFG_GAP        = 3'd3,
        CFG_HOLD       = 3'd4,
        CFG_MAX_CLICKS = 3'd5
    } t_cfg_idx;

    // Per-key record; all zero is the reset value
    typedef struct packed {
        logic               last_level;
        logic               press_reported;
        logic [TIME_W-1:0]  change_time;
        logic [TIME_W-1:0]  hold_time;
        logic [CLICK_W-1:0] click_count;
        logic [TIME_W-1:0]  click_time;
        t_event             reported_state;
    } t_key_rec;

    typedef struct packed {
        logic             rd_en;
        logic [KEY_W-1:0] rd_addr;
        logic             wr_en;
        logic [KEY_W-1:0] wr_addr;
    } t_mem_ctl;

endpackage

/* hw/rtl/kked_item_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kked_item_if
// Key sample channel: valid/ready handshake with key index, level and time.
// ----------------------------------------------------------------------------
interface kked_item_if;
    logic                        valid;
    logic                        ready;
    logic [kked_pkg::KEY_W-1:0]  key_index;
    logic                        key_level;
    logic [kked_pkg::TIME_W-1:0] time_ms;

    modport source (output valid, output key_index, output key_level, output time_ms,
                    input ready);
    modport sink   (input valid, input key_index, input key_level, input time_ms,
                    output ready);
endinterface

/* hw/rtl/kked_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kked_result_if
// Key event channel: valid/ready handshake with key id, event and status.
// ----------------------------------------------------------------------------
interface kked_result_if;
    logic                         valid;
    logic                         ready;
    logic [kked_pkg::KEY_W-1:0]   key_id;
    logic [kked_pkg::CODE_W-1:0]  event_code;
    logic [kked_pkg::CLICK_W-1:0] click_total;
    logic [kked_pkg::CODE_W-1:0]  key_status;

    modport source (output valid, output key_id, output event_code, output click_total,
                    output key_status, input ready);
    modport sink   (input valid, input key_id, input event_code, input click_total,
                    input key_status, output ready);
endinterface

/* hw/rtl/kked_key_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kked_key_mem
// Per-key record store: one write and one registered read per cycle, with
// a valid bit per entry so that an unwritten entry reads as all zero.
// ----------------------------------------------------------------------------
module kked_key_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kked_pkg::t_mem_ctl i_ctl,
    input  kked_pkg::t_key_rec i_wr_rec,
    output kked_pkg::t_key_rec o_rd_rec
);

    kked_pkg::t_key_rec              r_mem [kked_pkg::DEPTH];
    kked_pkg::t_key_rec              r_rd_data;
    logic [kked_pkg::DEPTH-1:0]      r_valid;
    logic                            r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_rec;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_ctl.wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_hit <= r_valid[i_ctl.rd_addr];
            end
        end
    end

    // Never-written entries read as the reset record
    assign o_rd_rec = r_rd_hit ? r_rd_data : '0;

endmodule

/* hw/rtl/keypad_key_event_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_key_event_detector
// Debounce, release, multi-click and repeating hold detection for the keys
// of a scanned matrix keypad, one key record read-modified-written per sample.
// ----------------------------------------------------------------------------
// Flow: the record is read into the memory read register in the transfer
// cycle, then updated, written back and loaded into the output register.
// A new sample is accepted only once the last one has been updated.
// The update waits while the output register holds an untaken result.
// Reset: all key records read as zero at once, control registers take defaults.
// ----------------------------------------------------------------------------
module keypad_key_event_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kked_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [kked_pkg::CFG_W-1:0]    i_cfg_data,
    kked_item_if.sink                     i_item,
    kked_result_if.source                 o_result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CALC = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [kked_pkg::CFG_W-1:0]   r_debounce;
    logic [kked_pkg::CFG_W-1:0]   r_click_min;
    logic [kked_pkg::CFG_W-1:0]   r_click_max;
    logic [kked_pkg::CFG_W-1:0]   r_gap;
    logic [kked_pkg::CFG_W-1:0]   r_hold_period;
    logic [kked_pkg::CLICK_W-1:0] r_max_clicks;

    logic [kked_pkg::KEY_W-1:0]   r_key;
    logic                         r_level;
    logic [kked_pkg::TIME_W-1:0]  r_time;

    logic                         r_out_valid;
    logic [kked_pkg::KEY_W-1:0]   r_out_key;
    kked_pkg::t_event             r_out_event;
    logic [kked_pkg::CLICK_W-1:0] r_out_total;
    kked_pkg::t_event             r_out_status;

    logic                         in_xfer;
    logic                         out_xfer;
    logic                         out_free;
    logic                         done;
    logic                         in_range;
    kked_pkg::t_mem_ctl           mem_ctl;
    kked_pkg::t_key_rec           rd_rec;
    kked_pkg::t_key_rec           n_rec;
    kked_pkg::t_event             n_event;
    logic [kked_pkg::CLICK_W-1:0] n_total;

    assign in_xfer  = i_item.valid && i_item.ready;
    assign out_xfer = o_result.valid && o_result.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign done     = (r_state == S_CALC) && out_free;
    assign in_range = {1'b0, r_key} < (kked_pkg::KEY_W + 1)'(kked_pkg::NUM_KEYS);

    assign i_item.ready = (r_state == S_IDLE);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce    <= kked_pkg::DEBOUNCE_RST;
            r_click_min   <= kked_pkg::CLICK_MIN_RST;
            r_click_max   <= kked_pkg::CLICK_MAX_RST;
            r_gap         <= kked_pkg::GAP_RST;
            r_hold_period <= kked_pkg::HOLD_RST;
            r_max_clicks  <= kked_pkg::MAX_CLICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kked_pkg::CFG_DEBOUNCE:   r_debounce    <= i_cfg_data;
                kked_pkg::CFG_CLICK_MIN:  r_click_min   <= i_cfg_data;
                kked_pkg::CFG_CLICK_MAX:  r_click_max   <= i_cfg_data;
                kked_pkg::CFG_GAP:        r_gap         <= i_cfg_data;
                kked_pkg::CFG_HOLD:       r_hold_period <= i_cfg_data;
                kked_pkg::CFG_MAX_CLICKS: r_max_clicks  <= i_cfg_data[kked_pkg::CLICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the sample while its record is read
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_key   <= i_item.key_index;
            r_level <= i_item.key_level;
            r_time  <= i_item.time_ms;
        end
    end

    always_comb begin
        mem_ctl.rd_en   = in_xfer;
        mem_ctl.rd_addr = i_item.key_index;
        mem_ctl.wr_en   = done && in_range;
        mem_ctl.wr_addr = r_key;
    end

    kked_key_mem u_key_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mem_ctl),
        .i_wr_rec (n_rec),
        .o_rd_rec (rd_rec)
    );

    // Record update for one sample
    always_comb begin
        logic [kked_pkg::TIME_W-1:0] since_change;
        logic [kked_pkg::TIME_W-1:0] since_click;
        logic [kked_pkg::TIME_W-1:0] since_hold;
        logic                        in_window;
        logic                        extend;

        since_change = r_time - rd_rec.change_time;
        since_click  = r_time - rd_rec.click_time;
        since_hold   = r_time - rd_rec.hold_time;
        in_window    = (since_change >= {16'd0, r_click_min}) &&
                       (since_change <= {16'd0, r_click_max});
        extend       = (rd_rec.click_count != '0) && (rd_rec.click_count < r_max_clicks) &&
                       (since_click < {16'd0, r_gap});

        n_rec   = rd_rec;
        n_event = kked_pkg::EV_NONE;
        n_total = '0;

        if (r_level != rd_rec.last_level) begin
            if (!r_level && rd_rec.press_reported) begin
                n_rec.press_reported = 1'b0;
                n_rec.reported_state = kked_pkg::EV_RELEASED;
                n_event              = kked_pkg::EV_RELEASED;
                if (in_window) begin
                    n_rec.click_count = extend ? rd_rec.click_count + 1'b1 :
                                                 kked_pkg::CLICK_W'(1);
                    n_rec.click_time  = r_time;
                end
            end
            n_rec.change_time = r_time;
            n_rec.hold_time   = r_time;
        end else if (r_level) begin
            if (!rd_rec.press_reported) begin
                if (since_change >= {16'd0, r_debounce}) begin
                    n_rec.press_reported = 1'b1;
                    n_rec.reported_state = kked_pkg::EV_PRESSED;
                    n_rec.hold_time      = r_time;
                    n_event              = kked_pkg::EV_PRESSED;
                end
            end else if (since_hold >= {16'd0, r_hold_period}) begin
                n_rec.hold_time      = rd_rec.hold_time + {16'd0, r_hold_period};
                n_rec.reported_state = kked_pkg::EV_HOLD;
                n_event              = kked_pkg::EV_HOLD;
            end
        end else if ((rd_rec.click_count != '0) && (since_click >= {16'd0, r_gap})) begin
            n_total              = rd_rec.click_count;
            n_rec.reported_state = kked_pkg::EV_CLICKED;
            n_rec.click_count    = '0;
            n_event              = kked_pkg::EV_CLICKED;
        end
        n_rec.last_level = r_level;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_key <= r_key;
            if (in_range) begin
                r_out_event  <= n_event;
                r_out_total  <= n_total;
                r_out_status <= n_rec.reported_state;
            end else begin
                r_out_event  <= kked_pkg::EV_NONE;
                r_out_total  <= '0;
                r_out_status <= kked_pkg::EV_NONE;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.key_id      = r_out_key;
    assign o_result.event_code  = r_out_event;
    assign o_result.click_total = r_out_total;
    assign o_result.key_status  = r_out_status;

`ifndef SYNTHESIS
    a_write_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.wr_en |-> (r_state == S_CALC))
        else $error("record write outside update state");

    a_xfer_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_CALC))
        else $error("sample transfer not followed by update");

    a_click_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_event == kked_pkg::EV_CLICKED) == (r_out_total != '0)))
        else $error("click total inconsistent with event");

    a_status_tracks_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_event != kked_pkg::EV_NONE)) |-> (r_out_status == r_out_event))
        else $error("key status differs from reported event");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_out_valid)
        else $error("finished update did not load output register");
`endif

endmodule

/* test/key_event_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_checker
// Watches the key sample and key event channels and the register write port
// of the keypad key event detector. Keeps its own per-key records, predicts
// the event of every accepted sample and compares it with the event that
// comes out, in order.
// ----------------------------------------------------------------------------
module key_event_checker
    import kked_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    kked_item_if              sample_bus,
    kked_result_if            event_bus,
    output int                o_error_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_click_reports
);

    typedef struct packed {
        logic [KEY_W-1:0]   key_id;
        t_event             event_code;
        logic [CLICK_W-1:0] click_total;
        t_event             key_status;
    } key_event_t;

    // Register copies
    logic [CFG_W-1:0]   debounce_ms;
    logic [CFG_W-1:0]   click_min_ms;
    logic [CFG_W-1:0]   click_max_ms;
    logic [CFG_W-1:0]   gap_ms;
    logic [CFG_W-1:0]   hold_period_ms;
    logic [CLICK_W-1:0] max_clicks;

    // Per-key records
    logic               level_q    [NUM_KEYS];
    logic               pressed_q  [NUM_KEYS];
    logic [TIME_W-1:0]  changed_at [NUM_KEYS];
    logic [TIME_W-1:0]  hold_at    [NUM_KEYS];
    logic [CLICK_W-1:0] clicks     [NUM_KEYS];
    logic [TIME_W-1:0]  clicked_at [NUM_KEYS];
    t_event             status_q   [NUM_KEYS];

    key_event_t expected_events [$];
    key_event_t want;
    int         mismatches;
    int         checked;
    int         click_reports;

    function automatic key_event_t predict_key_event(input logic [KEY_W-1:0] k,
                                                     input logic lvl,
                                                     input logic [TIME_W-1:0] now);
        key_event_t        res;
        logic [TIME_W-1:0] press_len;
        res.key_id      = k;
        res.event_code  = EV_NONE;
        res.click_total = '0;
        res.key_status  = EV_NONE;
        if (int'(k) >= NUM_KEYS) begin
            return res;
        end
        if (lvl != level_q[k]) begin
            if (!lvl && pressed_q[k]) begin
                press_len      = now - changed_at[k];
                pressed_q[k]   = 1'b0;
                status_q[k]    = EV_RELEASED;
                res.event_code = EV_RELEASED;
                if (press_len >= click_min_ms && press_len <= click_max_ms) begin
                    // extend the running sequence only inside the gap and below the cap
                    if (clicks[k] != 0 && clicks[k] < max_clicks &&
                        (now - clicked_at[k]) < gap_ms) begin
                        clicks[k] = clicks[k] + 1'b1;
                    end else begin
                        clicks[k] = 1;
                    end
                    clicked_at[k] = now;
                end
            end
            changed_at[k] = now;
            hold_at[k]    = now;
        end else if (lvl) begin
            if (!pressed_q[k]) begin
                if ((now - changed_at[k]) >= debounce_ms) begin
                    pressed_q[k]   = 1'b1;
                    status_q[k]    = EV_PRESSED;
                    hold_at[k]     = now;
                    res.event_code = EV_PRESSED;
                end
            end else if ((now - hold_at[k]) >= hold_period_ms) begin
                hold_at[k]     = hold_at[k] + hold_period_ms;
                status_q[k]    = EV_HOLD;
                res.event_code = EV_HOLD;
            end
        end else if (clicks[k] != 0 && (now - clicked_at[k]) >= gap_ms) begin
            res.click_total = clicks[k];
            status_q[k]     = EV_CLICKED;
            clicks[k]       = '0;
            res.event_code  = EV_CLICKED;
        end
        level_q[k]     = lvl;
        res.key_status = status_q[k];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int exp_val, input int got_val);
        mismatches++;
        $error("%s: expected %0d, got %0d", field, exp_val, got_val);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            debounce_ms    <= DEBOUNCE_RST;
            click_min_ms   <= CLICK_MIN_RST;
            click_max_ms   <= CLICK_MAX_RST;
            gap_ms         <= GAP_RST;
            hold_period_ms <= HOLD_RST;
            max_clicks     <= MAX_CLICKS_RST;
            for (int i = 0; i < NUM_KEYS; i++) begin
                level_q[i]    = 1'b0;
                pressed_q[i]  = 1'b0;
                changed_at[i] = '0;
                hold_at[i]    = '0;
                clicks[i]     = '0;
                clicked_at[i] = '0;
                status_q[i]   = EV_NONE;
            end
            expected_events.delete();
            mismatches = 0;
            checked    = 0;
            click_reports = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEBOUNCE:   debounce_ms    <= i_cfg_data;
                    CFG_CLICK_MIN:  click_min_ms   <= i_cfg_data;
                    CFG_CLICK_MAX:  click_max_ms   <= i_cfg_data;
                    CFG_GAP:        gap_ms         <= i_cfg_data;
                    CFG_HOLD:       hold_period_ms <= i_cfg_data;
                    CFG_MAX_CLICKS: max_clicks     <= i_cfg_data[CLICK_W-1:0];
                    default: ;
                endcase
            end
            if (event_bus.valid && event_bus.ready) begin
                if (expected_events.size() == 0) begin
                    mismatches++;
                    $error("unexpected key event for key %0d", event_bus.key_id);
                end else begin
                    want = expected_events.pop_front();
                    checked++;
                    if (event_bus.key_id !== want.key_id)
                        report_mismatch("key_id", want.key_id, event_bus.key_id);
                    if (event_bus.event_code !== want.event_code)
                        report_mismatch("event_code", want.event_code, event_bus.event_code);
                    if (event_bus.click_total !== want.click_total)
                        report_mismatch("click_total", want.click_total, event_bus.click_total);
                    if (event_bus.key_status !== want.key_status)
                        report_mismatch("key_status", want.key_status, event_bus.key_status);
                    if (want.event_code == EV_CLICKED)
                        click_reports++;
                end
            end
            if (sample_bus.valid && sample_bus.ready) begin
                expected_events.push_back(predict_key_event(sample_bus.key_index,
                                                            sample_bus.key_level,
                                                            sample_bus.time_ms));
            end
        end
        o_pending       <= expected_events.size();
        o_error_count   <= mismatches;
        o_checked       <= checked;
        o_click_reports <= click_reports;
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives key samples into the keypad key event detector: a short directed run
// of presses, holds, releases and multi-clicks, then random click bursts and
// noise under several register settings, with random gaps on both channels
// and two long receiver stalls. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module testbench;
    import kked_pkg::*;

    localparam int ITEM_TARGET  = 1850;
    localparam int NUM_SETTINGS = 9;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_STALL   = 120;

    localparam logic [CIDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic [CIDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    kked_item_if   sample_if ();
    kked_result_if event_if ();

    int error_count;
    int pending;
    int checked;
    int click_reports;
    int items_sent;
    bit idle_on;

    // Settings as last written, used to shape the stimulus
    int unsigned debounce_set;
    int unsigned click_min_set;
    int unsigned click_max_set;
    int unsigned gap_set;
    int unsigned hold_set;
    int unsigned max_clicks_set;

    logic [TIME_W-1:0] key_clock [NUM_KEYS];

    always #2 i_clk = ~i_clk;

    keypad_key_event_detector u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (sample_if),
        .o_result   (event_if)
    );

    key_event_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .sample_bus      (sample_if),
        .event_bus       (event_if),
        .o_error_count   (error_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_click_reports (click_reports)
    );

    function automatic int unsigned near_value(input int unsigned mark_ms);
        case ($urandom_range(0, 4))
            0: return (mark_ms == 0) ? 0 : mark_ms - 1;
            1: return mark_ms;
            2: return mark_ms + 1;
            default: return $urandom_range(0, 2 * mark_ms + 2);
        endcase
    endfunction

    task automatic send_sample(input logic [KEY_W-1:0] k, input logic lvl,
                               input logic [TIME_W-1:0] t);
        int unsigned gap_cycles;
        gap_cycles = idle_on ? $urandom_range(0, 3) : 0;
        repeat (gap_cycles) begin
            @(negedge i_clk);
            sample_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        sample_if.valid     <= 1'b1;
        sample_if.key_index <= k;
        sample_if.key_level <= lvl;
        sample_if.time_ms   <= t;
        do @(posedge i_clk); while (!(sample_if.valid && sample_if.ready));
        items_sent++;
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Drop valid and let every outstanding event come back
    task automatic drain_block();
        @(negedge i_clk);
        sample_if.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int phase);
        logic [CFG_W-1:0]   deb, cmin, cmax, gap, hold;
        logic [CLICK_W-1:0] mc;
        case (phase)
            1: begin
                deb = '0; cmin = '0; cmax = '0; gap = '0; hold = '0; mc = '0;
            end
            2: begin
                deb = '1; cmin = '1; cmax = '1; gap = '1; hold = '1; mc = '1;
            end
            default: begin
                deb  = CFG_W'($urandom_range(0, 100));
                cmin = CFG_W'($urandom_range(0, 60));
                cmax = cmin + CFG_W'($urandom_range(0, 400));
                gap  = CFG_W'($urandom_range(0, 600));
                hold = CFG_W'($urandom_range(1, 2000));
                mc   = CLICK_W'($urandom_range(1, 7));
            end
        endcase
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_CLICK_MIN, cmin);
        write_reg(CFG_CLICK_MAX, cmax);
        write_reg(CFG_GAP, gap);
        write_reg(CFG_HOLD, hold);
        // upper data bits are don't-care for the click cap
        write_reg(CFG_MAX_CLICKS, {(CFG_W - CLICK_W)'($urandom_range(0, 8191)), mc});
        if (phase == 1) begin
            write_reg(CFG_IDX_SPARE_LO, CFG_W'($urandom));
            write_reg(CFG_IDX_SPARE_HI, CFG_W'($urandom));
        end
        debounce_set   = deb;
        click_min_set  = cmin;
        click_max_set  = cmax;
        gap_set        = gap;
        hold_set       = hold;
        max_clicks_set = mc;
    endtask

    // One key: a run of taps, some long enough to hold, then maybe the report
    task automatic click_burst(input logic [KEY_W-1:0] k);
        int unsigned       taps, settle, press_len, holds;
        logic [TIME_W-1:0] t_down, t_now;
        taps = $urandom_range(1, max_clicks_set + 1);
        for (int i = 0; i < taps; i++) begin
            if (i == 0)
                t_down = key_clock[k] + near_value(gap_set);
            else
                t_down = key_clock[k] + $urandom_range(0, gap_set / 2 + 1);
            send_sample(k, 1'b1, t_down);
            settle = near_value(debounce_set);
            holds  = 0;
            case ($urandom_range(0, 5))
                0: press_len = near_value(click_min_set);
                1: press_len = near_value(click_max_set);
                2: begin
                    press_len = settle + near_value(hold_set);
                    holds     = $urandom_range(1, 3);
                end
                default: press_len = $urandom_range(click_min_set, click_max_set);
            endcase
            t_now = t_down + settle;
            if (press_len > settle)
                send_sample(k, 1'b1, t_now);
            repeat (holds) begin
                t_now += near_value(hold_set);
                send_sample(k, 1'b1, t_now);
            end
            if (holds > 0)
                press_len = t_now - t_down + $urandom_range(0, 3);
            key_clock[k] = t_down + press_len;
            send_sample(k, 1'b0, key_clock[k]);
        end
        if ($urandom_range(0, 3) != 0) begin
            key_clock[k] += near_value(gap_set);
            send_sample(k, 1'b0, key_clock[k]);
        end
    endtask

    // Event receiver: random hold-offs, plus two long stalls to back up the block
    initial begin : event_sink
        int unsigned sink_wait;
        int          taken;
        sink_wait = 0;
        taken     = 0;
        event_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_wait > 0) begin
                event_if.ready <= 1'b0;
                sink_wait--;
            end else begin
                event_if.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (event_if.valid && event_if.ready) begin
                taken++;
                if (taken == 400 || taken == 1300)
                    sink_wait = LONG_STALL;
                else
                    sink_wait = idle_on ? $urandom_range(0, 3) : 0;
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (sample_if.valid && sample_if.ready) ||
                (event_if.valid && event_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        sample_if.valid     = 1'b0;
        sample_if.key_index = '0;
        sample_if.key_level = 1'b0;
        sample_if.time_ms   = '0;
        items_sent     = 0;
        idle_on        = 1'b1;
        debounce_set   = DEBOUNCE_RST;
        click_min_set  = CLICK_MIN_RST;
        click_max_set  = CLICK_MAX_RST;
        gap_set        = GAP_RST;
        hold_set       = HOLD_RST;
        max_clicks_set = MAX_CLICKS_RST;
        for (int i = 0; i < NUM_KEYS; i++)
            key_clock[i] = $urandom;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // long press: debounce, one hold, release outside the click window
        send_sample(4'd0, 1'b1, 32'd0);
        send_sample(4'd0, 1'b1, 32'd20);
        send_sample(4'd0, 1'b1, 32'd1020);
        send_sample(4'd0, 1'b0, 32'd1100);
        // release before the press is reported, then a click across the time wrap
        send_sample(4'd15, 1'b1, 32'hFFFF_FFF0);
        send_sample(4'd15, 1'b0, 32'hFFFF_FFF5);
        send_sample(4'd15, 1'b1, 32'hFFFF_FFF8);
        send_sample(4'd15, 1'b1, 32'h0000_000C);
        send_sample(4'd15, 1'b0, 32'h0000_0020);
        send_sample(4'd15, 1'b0, 32'h0000_01B0);
        // four quick taps: the count stops at the cap and restarts
        for (int i = 0; i < 4; i++) begin
            send_sample(4'd5, 1'b1, 32'(100 * i));
            send_sample(4'd5, 1'b1, 32'(100 * i + 20));
            send_sample(4'd5, 1'b0, 32'(100 * i + 50));
        end
        send_sample(4'd5, 1'b0, 32'd750);

        for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
            if (phase > 0) begin
                drain_block();
                apply_setting(phase);
            end
            while (items_sent < (phase + 1) * ITEM_TARGET / NUM_SETTINGS) begin
                idle_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 4) == 0)
                    send_sample(KEY_W'($urandom), 1'($urandom), $urandom);
                else
                    click_burst(KEY_W'($urandom_range(0, NUM_KEYS - 1)));
            end
        end
        drain_block();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d key samples under %0d register settings, with gaps and stalls.",
                 items_sent, NUM_SETTINGS);
        $display("Checked %0d key events, %0d of them multi-click reports.",
                 checked, click_reports);
        if (error_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* keypad_key_event_detector.f */
hw/rtl/kked_pkg.sv
hw/rtl/kked_item_if.sv
hw/rtl/kked_result_if.sv
hw/rtl/kked_key_mem.sv
hw/rtl/keypad_key_event_detector.sv
test/key_event_checker.sv
test/testbench.sv
